// ----- rtl/core/lic_pkg.sv -----
// Shared types and constants for the linear index to coordinates block.
`default_nettype none
package lic_pkg;
    localparam int TUPLE_W = 48;
    localparam int EXT_W   = 16;
    localparam int ORG_W   = 32;
    localparam int COORD_W = 33;
    localparam int SPAN_W  = 32;
    localparam int QBITS   = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 32;

    localparam logic [IDX_W-1:0] REG_DIM_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXTENT_0  = 3'd1;
    localparam logic [IDX_W-1:0] REG_EXTENT_1  = 3'd2;
    localparam logic [IDX_W-1:0] REG_EXTENT_2  = 3'd3;
    localparam logic [IDX_W-1:0] REG_ORIGIN_0  = 3'd4;
    localparam logic [IDX_W-1:0] REG_ORIGIN_1  = 3'd5;
    localparam logic [IDX_W-1:0] REG_ORIGIN_2  = 3'd6;

    typedef struct packed {
        logic [1:0]       dim_count;
        logic [EXT_W-1:0] extent_0;
        logic [EXT_W-1:0] extent_1;
        logic [EXT_W-1:0] extent_2;
        logic [ORG_W-1:0] origin_0;
        logic [ORG_W-1:0] origin_1;
        logic [ORG_W-1:0] origin_2;
    } t_cfg;

    // Word handed from the range check stages to the divider chain.
    typedef struct packed {
        logic              valid;
        logic              err;
        logic [TUPLE_W-1:0] rem;
        logic [SPAN_W-1:0] span;
    } t_prep;

    // Word leaving the divider chain.
    typedef struct packed {
        logic             valid;
        logic             err;
        logic [QBITS-1:0] digit_0;
        logic [QBITS-1:0] digit_1;
        logic [EXT_W-1:0] digit_2;
    } t_digits;
endpackage
`default_nettype wire

// ----- rtl/core/linear_index_to_coordinates.sv -----
// Top level: configuration registers, pipeline, origin add and output word.
//
// Splits a one-based 48-bit tuple number into up to three mixed-radix
// coordinates, dimension 0 most significant, each offset by its origin.
// Input channel: i_valid / o_stall with i_tuple_number; a word is taken
// at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_coord_0..2 and o_range_error.
// Configuration: write i_cfg_data to register i_cfg_idx when i_cfg_we is
// high (0 dim count, 1..3 extents, 4..6 origins); only while idle.
// The pipeline has three range-check stages (span multiply, extent
// product, compare), sixteen restoring steps for the first digit, sixteen
// for the second and third, and the output register. It takes one word
// per cycle while the receiver does not stall; every stage holds one word.
// Reset clears all valid bits and sets dim count 1, extents 1, origins 0.
// When the receiver stalls with a word waiting, o_stall rises and the
// whole pipeline holds; nothing is dropped or repeated.
// A zero or too-large tuple number flags o_range_error; coords are origins.
`default_nettype none
module linear_index_to_coordinates (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [lic_pkg::TUPLE_W-1:0] i_tuple_number,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [lic_pkg::COORD_W-1:0]      o_coord_0,
    output logic [lic_pkg::COORD_W-1:0]      o_coord_1,
    output logic [lic_pkg::COORD_W-1:0]      o_coord_2,
    output logic                             o_range_error,
    input  wire logic                        i_cfg_we,
    input  wire logic [lic_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [lic_pkg::DATA_W-1:0]  i_cfg_data
);
    lic_pkg::t_cfg    r_cfg;
    lic_pkg::t_prep   prep;
    lic_pkg::t_digits digits;
    logic             adv;
    logic             r_out_v;

    // Advance every stage unless a finished word waits on a stalled receiver.
    assign adv     = !r_out_v || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dim_count <= 2'd1;
            r_cfg.extent_0  <= lic_pkg::EXT_W'(1);
            r_cfg.extent_1  <= lic_pkg::EXT_W'(1);
            r_cfg.extent_2  <= lic_pkg::EXT_W'(1);
            r_cfg.origin_0  <= '0;
            r_cfg.origin_1  <= '0;
            r_cfg.origin_2  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lic_pkg::REG_DIM_COUNT: r_cfg.dim_count <= i_cfg_data[1:0];
                lic_pkg::REG_EXTENT_0:  r_cfg.extent_0  <= i_cfg_data[lic_pkg::EXT_W-1:0];
                lic_pkg::REG_EXTENT_1:  r_cfg.extent_1  <= i_cfg_data[lic_pkg::EXT_W-1:0];
                lic_pkg::REG_EXTENT_2:  r_cfg.extent_2  <= i_cfg_data[lic_pkg::EXT_W-1:0];
                lic_pkg::REG_ORIGIN_0:  r_cfg.origin_0  <= i_cfg_data;
                lic_pkg::REG_ORIGIN_1:  r_cfg.origin_1  <= i_cfg_data;
                lic_pkg::REG_ORIGIN_2:  r_cfg.origin_2  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lic_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_tuple (i_tuple_number),
        .i_cfg   (r_cfg),
        .o_prep  (prep)
    );

    lic_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_prep   (prep),
        .i_cfg    (r_cfg),
        .o_digits (digits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= digits.valid;
        end
    end

    // Drop the digits on a range error so each coord is its origin alone.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_range_error <= digits.err;
            o_coord_0 <= {1'b0, r_cfg.origin_0} + (digits.err ? '0 :
                         {{(lic_pkg::COORD_W-lic_pkg::QBITS){1'b0}}, digits.digit_0});
            o_coord_1 <= {1'b0, r_cfg.origin_1} + (digits.err ? '0 :
                         {{(lic_pkg::COORD_W-lic_pkg::QBITS){1'b0}}, digits.digit_1});
            o_coord_2 <= {1'b0, r_cfg.origin_2} + (digits.err ? '0 :
                         {{(lic_pkg::COORD_W-lic_pkg::EXT_W){1'b0}}, digits.digit_2});
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/lic_prep.sv -----
// Range check stages: span of the lower dimensions, extent product, range flag.
`default_nettype none
module lic_prep (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_valid,
    input  wire logic [lic_pkg::TUPLE_W-1:0] i_tuple,
    input  wire lic_pkg::t_cfg               i_cfg,
    output lic_pkg::t_prep                   o_prep
);
    logic [1:0]                 used;
    logic [lic_pkg::EXT_W-1:0]  m1;
    logic [lic_pkg::EXT_W-1:0]  m2;

    logic                        r_v1, r_v2, r_v3;
    logic                        r_tz1, r_tz2, r_err3;
    logic [lic_pkg::TUPLE_W-1:0] r_t1, r_t2;
    logic [lic_pkg::TUPLE_W-1:0] r_rem1, r_rem2, r_rem3;
    logic [lic_pkg::SPAN_W-1:0]  r_s1, r_s2, r_s3;
    logic [lic_pkg::TUPLE_W-1:0] r_total2;

    always_comb begin
        used = (i_cfg.dim_count == 2'd0) ? 2'd1 : i_cfg.dim_count;
        m1   = (used >= 2'd2) ? i_cfg.extent_1 : lic_pkg::EXT_W'(1);
        m2   = (used == 2'd3) ? i_cfg.extent_2 : lic_pkg::EXT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_t1     <= i_tuple;
            r_tz1    <= (i_tuple == '0);
            r_rem1   <= i_tuple - lic_pkg::TUPLE_W'(1);
            r_s1     <= m1 * m2;
            r_t2     <= r_t1;
            r_tz2    <= r_tz1;
            r_rem2   <= r_rem1;
            r_s2     <= r_s1;
            r_total2 <= {{(lic_pkg::TUPLE_W-lic_pkg::EXT_W){1'b0}}, i_cfg.extent_0}
                        * {{(lic_pkg::TUPLE_W-lic_pkg::SPAN_W){1'b0}}, r_s1};
            r_err3   <= r_tz2 || (r_t2 > r_total2);
            r_rem3   <= r_rem2;
            r_s3     <= r_s2;
        end
    end

    assign o_prep = '{valid: r_v3, err: r_err3, rem: r_rem3, span: r_s3};
endmodule
`default_nettype wire

// ----- rtl/core/lic_div.sv -----
// Divider chain: one restoring quotient bit per stage, two divisions in series.
`default_nettype none
module lic_div (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire lic_pkg::t_prep  i_prep,
    input  wire lic_pkg::t_cfg   i_cfg,
    output lic_pkg::t_digits     o_digits
);
    localparam int QB = lic_pkg::QBITS;
    localparam int TW = lic_pkg::TUPLE_W;
    localparam int SW = lic_pkg::SPAN_W;

    logic [lic_pkg::EXT_W-1:0] div2;

    // First division: remainder over the span of the lower dimensions.
    logic          r_av   [0:QB-1];
    logic          r_aerr [0:QB-1];
    logic [TW-1:0] r_arem [0:QB-1];
    logic [SW-1:0] r_aspn [0:QB-1];
    logic [QB-1:0] r_aq   [0:QB-1];

    // Second division: leftover over extent 2, or over 1 with fewer than three dimensions.
    logic          r_bv   [0:QB-1];
    logic          r_berr [0:QB-1];
    logic [SW-1:0] r_brem [0:QB-1];
    logic [QB-1:0] r_bq1  [0:QB-1];
    logic [QB-1:0] r_bq   [0:QB-1];

    always_comb begin
        div2 = ((i_cfg.dim_count == 2'd3)) ? i_cfg.extent_2 : lic_pkg::EXT_W'(1);
    end

    for (genvar j = 0; j < QB; j++) begin : g_a
        localparam int SH = QB - 1 - j;
        logic          pv, perr;
        logic [TW-1:0] prem, dsh;
        logic [SW-1:0] pspn;
        logic [QB-1:0] pq;
        logic [QB-1:0] n_q;
        logic          take;
        if (j == 0) begin : g_first
            assign pv   = i_prep.valid;
            assign perr = i_prep.err;
            assign prem = i_prep.rem;
            assign pspn = i_prep.span;
            assign pq   = '0;
        end else begin : g_next
            assign pv   = r_av[j-1];
            assign perr = r_aerr[j-1];
            assign prem = r_arem[j-1];
            assign pspn = r_aspn[j-1];
            assign pq   = r_aq[j-1];
        end
        assign dsh  = {{(TW-SW){1'b0}}, pspn} << SH;
        assign take = (prem >= dsh);
        assign n_q  = pq | (QB'(take) << SH);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[j] <= 1'b0;
            end else if (i_adv) begin
                r_av[j] <= pv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_aerr[j] <= perr;
                r_aspn[j] <= pspn;
                r_arem[j] <= take ? (prem - dsh) : prem;
                r_aq[j]   <= n_q;
            end
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_b
        localparam int SH = QB - 1 - j;
        logic          pv, perr;
        logic [SW-1:0] prem, dsh;
        logic [QB-1:0] pq, pq1;
        logic [QB-1:0] n_q;
        logic          take;
        if (j == 0) begin : g_first
            assign pv   = r_av[QB-1];
            assign perr = r_aerr[QB-1];
            assign prem = r_arem[QB-1][SW-1:0];
            assign pq1  = r_aq[QB-1];
            assign pq   = '0;
        end else begin : g_next
            assign pv   = r_bv[j-1];
            assign perr = r_berr[j-1];
            assign prem = r_brem[j-1];
            assign pq1  = r_bq1[j-1];
            assign pq   = r_bq[j-1];
        end
        assign dsh  = {{(SW-lic_pkg::EXT_W){1'b0}}, div2} << SH;
        assign take = (prem >= dsh);
        assign n_q  = pq | (QB'(take) << SH);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bv[j] <= 1'b0;
            end else if (i_adv) begin
                r_bv[j] <= pv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_berr[j] <= perr;
                r_bq1[j]  <= pq1;
                r_brem[j] <= take ? (prem - dsh) : prem;
                r_bq[j]   <= n_q;
            end
        end
    end

    assign o_digits = '{valid:   r_bv[QB-1],
                        err:     r_berr[QB-1],
                        digit_0: r_bq1[QB-1],
                        digit_1: r_bq[QB-1],
                        digit_2: r_brem[QB-1][lic_pkg::EXT_W-1:0]};
endmodule
`default_nettype wire
